>>> hdl/bbsc_pkg.sv
// shared constants for the box boundary bounce and speed clamp block
// no dependencies
package bbsc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DAMP_FRAC       = 16;
    localparam int DAMP_WIDTH      = 17;
    localparam int CFG_IDX_WIDTH   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MARGIN      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_SIZE    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DAMPING     = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_LIMIT = 2'd3;

    // reset values
    localparam logic [63:0]           BOX_SIZE_RST = 64'h0000_0000_4000_0000;
    localparam logic [DAMP_WIDTH-1:0] DAMPING_RST  = 17'h10000;

endpackage

>>> hdl/bbsc_bounce.sv
// wall test, damped bounce, saturation and squared speed (five stages)
// depends on bbsc_pkg
module bbsc_bounce import bbsc_pkg::*; #(
    parameter int W = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_pos_x,
    input  logic signed [W-1:0]   i_pos_y,
    input  logic signed [W-1:0]   i_vel_x,
    input  logic signed [W-1:0]   i_vel_y,
    input  logic                  i_asleep,
    input  logic [W-2:0]          i_margin,
    input  logic [W-2:0]          i_box_size,
    input  logic [DAMP_WIDTH-1:0] i_damping,
    output logic                  o_valid,
    output logic [4*W:0]          o_side,
    output logic [2*W-1:0]        o_sq
);

    localparam int PW = W + DAMP_WIDTH;
    localparam logic [W:0] HALF = (W+1)'(1) << (W-1);

    // stage 1: wall compare and velocity magnitude
    logic signed [W:0] n_lo, n_hi, n_px, n_py;
    logic              n_lx, n_hx, n_ly, n_hy;
    logic signed [W-1:0] r1_px, r1_py, r1_vx, r1_vy;
    logic [W-1:0]      r1_mx, r1_my;
    logic              r1_lx, r1_hx, r1_ly, r1_hy, r1_vld;

    always_comb begin
        n_lo = $signed({2'b00, i_margin});
        n_hi = $signed({2'b00, i_box_size}) - $signed({2'b00, i_margin});
        n_px = (W+1)'(i_pos_x);
        n_py = (W+1)'(i_pos_y);
        n_lx = !i_asleep && (n_px < n_lo);
        n_hx = !i_asleep && !n_lx && (n_px > n_hi);
        n_ly = !i_asleep && (n_py < n_lo);
        n_hy = !i_asleep && !n_ly && (n_py > n_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
        if (i_en) begin
            r1_px <= n_lx ? n_lo[W-1:0] : (n_hx ? n_hi[W-1:0] : i_pos_x);
            r1_py <= n_ly ? n_lo[W-1:0] : (n_hy ? n_hi[W-1:0] : i_pos_y);
            r1_vx <= i_vel_x;
            r1_vy <= i_vel_y;
            r1_mx <= i_vel_x[W-1] ? W'(-i_vel_x) : W'(i_vel_x);
            r1_my <= i_vel_y[W-1] ? W'(-i_vel_y) : W'(i_vel_y);
            r1_lx <= n_lx;
            r1_hx <= n_hx;
            r1_ly <= n_ly;
            r1_hy <= n_hy;
        end
    end

    // stage 2: damping products
    logic signed [W-1:0] r2_px, r2_py, r2_vx, r2_vy;
    logic [PW-1:0]     r2_dx, r2_dy;
    logic              r2_lx, r2_hx, r2_ly, r2_hy, r2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_px <= r1_px;
            r2_py <= r1_py;
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_dx <= PW'(r1_mx) * PW'(i_damping);
            r2_dy <= PW'(r1_my) * PW'(i_damping);
            r2_lx <= r1_lx;
            r2_hx <= r1_hx;
            r2_ly <= r1_ly;
            r2_hy <= r1_hy;
        end
    end

    // stage 3: new velocity with saturation
    logic [W:0]          n_mx, n_my;
    logic signed [W-1:0] n_vx, n_vy;
    logic signed [W-1:0] r3_px, r3_py, r3_vx, r3_vy;
    logic                r3_hit, r3_vld;

    always_comb begin
        n_mx = r2_dx[DAMP_FRAC +: W+1];
        n_my = r2_dy[DAMP_FRAC +: W+1];
        n_vx = r2_vx;
        n_vy = r2_vy;
        if (r2_lx) begin
            n_vx = (n_mx >= HALF) ? W'(HALF - 1'b1) : W'(n_mx);
        end else if (r2_hx) begin
            n_vx = (n_mx >= HALF) ? W'(HALF) : W'(-n_mx);
        end
        if (r2_ly) begin
            n_vy = (n_my >= HALF) ? W'(HALF - 1'b1) : W'(n_my);
        end else if (r2_hy) begin
            n_vy = (n_my >= HALF) ? W'(HALF) : W'(-n_my);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r3_vx  <= n_vx;
            r3_vy  <= n_vy;
            r3_hit <= r2_lx | r2_hx | r2_ly | r2_hy;
        end
    end

    // stage 4: squares of the velocity magnitudes
    logic [W-1:0]        n_ax, n_ay;
    logic [2*W-1:0]      r4_sx, r4_sy;
    logic signed [W-1:0] r4_px, r4_py, r4_vx, r4_vy;
    logic                r4_hit, r4_vld;

    assign n_ax = r3_vx[W-1] ? W'(-r3_vx) : W'(r3_vx);
    assign n_ay = r3_vy[W-1] ? W'(-r3_vy) : W'(r3_vy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
        if (i_en) begin
            r4_sx  <= (2*W)'(n_ax) * (2*W)'(n_ax);
            r4_sy  <= (2*W)'(n_ay) * (2*W)'(n_ay);
            r4_px  <= r3_px;
            r4_py  <= r3_py;
            r4_vx  <= r3_vx;
            r4_vy  <= r3_vy;
            r4_hit <= r3_hit;
        end
    end

    // stage 5: sum of squares
    logic [2*W-1:0] r5_sq;
    logic [4*W:0]   r5_side;
    logic           r5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
        if (i_en) begin
            r5_sq   <= r4_sx + r4_sy;
            r5_side <= {r4_hit, r4_vy, r4_vx, r4_py, r4_px};
        end
    end

    assign o_valid = r5_vld;
    assign o_sq    = r5_sq;
    assign o_side  = r5_side;

endmodule

>>> hdl/bbsc_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on bbsc_pkg
module bbsc_sqrt import bbsc_pkg::*; #(
    parameter int W  = VALUE_WIDTH_DEF,
    parameter int SW = 4*VALUE_WIDTH_DEF+1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [2*W-1:0] i_rad,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [W-1:0]   o_root,
    output logic [SW-1:0]  o_side
);

    logic [2*W-1:0] r_rem  [0:W];
    logic [W-1:0]   r_root [0:W];
    logic [SW-1:0]  r_side [0:W];
    logic           r_vld  [0:W];

    assign r_rem[0]  = i_rad;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;
    assign r_vld[0]  = i_valid;

    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int K = W - 1 - g;
        logic [2*W-1:0] n_trial;
        logic           n_take;

        // trial subtrahend 2*root*2^k + 4^k
        assign n_trial = ((2*W)'(r_root[g]) << (K + 1)) | ((2*W)'(1) << (2 * K));
        assign n_take  = r_rem[g] >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_rem[g+1]  <= n_take ? r_rem[g] - n_trial : r_rem[g];
                r_root[g+1] <= n_take ? (r_root[g] | (W'(1) << K)) : r_root[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[W];
    assign o_root  = r_root[W];
    assign o_side  = r_side[W];

endmodule

>>> hdl/bbsc_div.sv
// speed clamp: products, pipelined restoring division per component, output register
// depends on bbsc_pkg
module bbsc_div import bbsc_pkg::*; #(
    parameter int W = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_root,
    input  logic [4*W:0]  i_side,
    input  logic [W-2:0]  i_limit,
    output logic          o_valid,
    output logic [4*W:0]  o_side
);

    localparam int QB = W - 1;

    // stage a: clamp decision and numerators
    logic signed [W-1:0] n_vx, n_vy;
    logic [W-1:0]        n_ax, n_ay;
    logic [2*W-1:0]      r_nx [0:QB];
    logic [2*W-1:0]      r_ny [0:QB];
    logic [QB-1:0]       r_qx [0:QB];
    logic [QB-1:0]       r_qy [0:QB];
    logic [W-1:0]        r_den  [0:QB];
    logic [4*W:0]        r_side [0:QB];
    logic                r_clamp [0:QB];
    logic                r_vld   [0:QB];

    assign n_vx = i_side[2*W +: W];
    assign n_vy = i_side[3*W +: W];
    assign n_ax = n_vx[W-1] ? W'(-n_vx) : W'(n_vx);
    assign n_ay = n_vy[W-1] ? W'(-n_vy) : W'(n_vy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_nx[0]    <= (2*W)'(n_ax) * (2*W)'(i_limit);
            r_ny[0]    <= (2*W)'(n_ay) * (2*W)'(i_limit);
            r_qx[0]    <= '0;
            r_qy[0]    <= '0;
            r_den[0]   <= i_root;
            r_side[0]  <= i_side;
            r_clamp[0] <= i_side[4*W] && (i_root > W'(i_limit));
        end
    end

    // one quotient bit per stage for both components
    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int K = QB - 1 - g;
        logic [2*W-1:0] n_sub;
        logic           n_tx, n_ty;

        assign n_sub = (2*W)'(r_den[g]) << K;
        assign n_tx  = r_nx[g] >= n_sub;
        assign n_ty  = r_ny[g] >= n_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_nx[g+1]    <= n_tx ? r_nx[g] - n_sub : r_nx[g];
                r_ny[g+1]    <= n_ty ? r_ny[g] - n_sub : r_ny[g];
                r_qx[g+1]    <= n_tx ? (r_qx[g] | (QB'(1) << K)) : r_qx[g];
                r_qy[g+1]    <= n_ty ? (r_qy[g] | (QB'(1) << K)) : r_qy[g];
                r_den[g+1]   <= r_den[g];
                r_side[g+1]  <= r_side[g];
                r_clamp[g+1] <= r_clamp[g];
            end
        end
    end

    // output register: apply sign to the quotient when clamping
    logic signed [W-1:0] n_ox, n_oy, n_sx, n_sy;
    logic [4*W:0]        r_out;
    logic                r_out_vld;

    always_comb begin
        n_sx = r_side[QB][2*W +: W];
        n_sy = r_side[QB][3*W +: W];
        n_ox = n_sx;
        n_oy = n_sy;
        if (r_clamp[QB]) begin
            n_ox = n_sx[W-1] ? -$signed(W'(r_qx[QB])) : $signed(W'(r_qx[QB]));
            n_oy = n_sy[W-1] ? -$signed(W'(r_qy[QB])) : $signed(W'(r_qy[QB]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QB];
        end
        if (i_en) begin
            r_out <= {r_side[QB][4*W], n_oy, n_ox, r_side[QB][2*W-1:0]};
        end
    end

    assign o_valid = r_out_vld;
    assign o_side  = r_out;

endmodule

>>> hdl/box_boundary_bounce_speed_clamp.sv
// Reflective square-box boundary with damped bounce and post-bounce speed clamp.
// One body per beat enters and one result per beat leaves. Each passes through
// five stages of wall test, damping and squaring, one stage per root bit of the
// square root, one product stage, one stage per quotient bit of the clamp
// division and the output register. All stages advance together; the pipeline
// holds whenever the output beat is not taken. Configuration is written through
// its own channel, always ready.
module box_boundary_bounce_speed_clamp import bbsc_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // in_pos_x, in_pos_y, in_vel_x, in_vel_y from the lowest bit up
    input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // asleep
    input  logic [0:0]                 i_s_tuser,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y from the lowest bit up
    output logic [((4*VALUE_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // bounced
    output logic [0:0]                 o_m_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]     i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int DW = ((4*W+7)/8)*8;

    // configuration registers
    logic [W-2:0]          r_margin, r_box_size, r_speed_limit;
    logic [DAMP_WIDTH-1:0] r_damping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin      <= '0;
            r_box_size    <= BOX_SIZE_RST[W-2:0];
            r_damping     <= DAMPING_RST;
            r_speed_limit <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MARGIN:      r_margin      <= i_cfg_data[W-2:0];
                REG_BOX_SIZE:    r_box_size    <= i_cfg_data[W-2:0];
                REG_DAMPING:     r_damping     <= i_cfg_data[DAMP_WIDTH-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[W-2:0];
                default:         ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // global advance: the last stage is free or being drained
    logic en;
    logic out_vld;
    assign en         = !out_vld || i_m_tready;
    assign o_s_tready = en;

    logic           b_vld, s_vld;
    logic [4*W:0]   b_side, s_side, d_side;
    logic [2*W-1:0] b_sq;
    logic [W-1:0]   s_root;

    bbsc_bounce #(.W(W)) u_bounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_tvalid),
        .i_pos_x    (i_s_tdata[0 +: W]),
        .i_pos_y    (i_s_tdata[W +: W]),
        .i_vel_x    (i_s_tdata[2*W +: W]),
        .i_vel_y    (i_s_tdata[3*W +: W]),
        .i_asleep   (i_s_tuser[0]),
        .i_margin   (r_margin),
        .i_box_size (r_box_size),
        .i_damping  (r_damping),
        .o_valid    (b_vld),
        .o_side     (b_side),
        .o_sq       (b_sq)
    );

    bbsc_sqrt #(.W(W), .SW(4*W+1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_vld),
        .i_rad   (b_sq),
        .i_side  (b_side),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    bbsc_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_vld),
        .i_root  (s_root),
        .i_side  (s_side),
        .i_limit (r_speed_limit),
        .o_valid (out_vld),
        .o_side  (d_side)
    );

    assign o_m_tvalid = out_vld;
    assign o_m_tdata  = DW'(d_side[4*W-1:0]);
    assign o_m_tuser  = d_side[4*W];

endmodule

>>> hdl/bbsc_checker.sv
// port-level checks for the bounce and clamp block, bound to the top level
// depends on bbsc_pkg
module bbsc_checker import bbsc_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_tready,
    input logic [((4*VALUE_WIDTH+7)/8)*8-1:0] o_m_tdata,
    input logic [0:0]                         o_m_tuser,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result payload changed while stalled");

    // input side advances exactly when the output slot is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready out of step with output");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind box_boundary_bounce_speed_clamp bbsc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_bbsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

>>> tb/tb_top.sv
// testbench for the box boundary bounce and speed clamp block
// depends on bbsc_pkg and box_boundary_bounce_speed_clamp; self-checking, no files read
`timescale 1ns / 1ps

module tb_top;
    import bbsc_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = 2 * W + 6;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM = 1100;

    typedef struct packed {
        logic [W-1:0] vy;
        logic [W-1:0] vx;
        logic [W-1:0] py;
        logic [W-1:0] px;
        logic         flag;
    } t_body;

    // wall and clamp settings mirrored from the configuration writes
    logic [30:0] wall_margin;
    logic [30:0] world_size;
    logic [16:0] bounce_damp;
    logic [30:0] max_speed;

    function automatic logic [63:0] abs_val(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] sat_signed(input logic neg, input logic [63:0] m);
        if (neg) return (m >= 64'h8000_0000) ? -64'sh8000_0000 : -$signed(m);
        return (m >= 64'h8000_0000) ? 64'sh7FFF_FFFF : $signed(m);
    endfunction

    // one axis of the wall reflection, returns 1 on a hit
    function automatic logic reflect_axis(inout logic signed [63:0] p,
                                          inout logic signed [63:0] v);
        logic signed [63:0] lo_wall;
        logic signed [63:0] hi_wall;
        logic [63:0] m;
        lo_wall = $signed({33'd0, wall_margin});
        hi_wall = $signed({33'd0, world_size}) - lo_wall;
        m = (abs_val(v) * {47'd0, bounce_damp}) >> DAMP_FRAC;
        if (p < lo_wall) begin
            p = lo_wall;
            v = sat_signed(1'b0, m);
            return 1'b1;
        end
        if (p > hi_wall) begin
            p = hi_wall;
            v = sat_signed(1'b1, m);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] int_root(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 49; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    function automatic t_body bounce_body(input t_body b);
        logic signed [63:0] px, py, vx, vy;
        logic hx, hy;
        logic [127:0] sq;
        logic [63:0] spd;
        t_body r;
        px = $signed(b.px); py = $signed(b.py);
        vx = $signed(b.vx); vy = $signed(b.vy);
        hx = 0; hy = 0;
        if (!b.flag) begin
            hx = reflect_axis(px, vx);
            hy = reflect_axis(py, vy);
            if (hx || hy) begin
                sq = {64'd0, abs_val(vx)} * {64'd0, abs_val(vx)}
                   + {64'd0, abs_val(vy)} * {64'd0, abs_val(vy)};
                spd = int_root(sq);
                if (spd > {33'd0, max_speed}) begin
                    vx = sat_signed(vx < 0, 64'(({64'd0, abs_val(vx)} * max_speed) / spd));
                    vy = sat_signed(vy < 0, 64'(({64'd0, abs_val(vy)} * max_speed) / spd));
                end
            end
        end
        r.px = px[W-1:0]; r.py = py[W-1:0];
        r.vx = vx[W-1:0]; r.vy = vy[W-1:0];
        r.flag = hx || hy;
        return r;
    endfunction

    class t_bounce_scoreboard;
        t_body pending[$];
        int errors;

        function void note_body(t_body b);
            pending.push_back(bounce_body(b));
        endfunction

        function void check_result(t_body got);
            t_body exp;
            if (pending.size() == 0) begin
                report("unexpected beat", got, got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) report("mismatch", exp, got);
        endfunction

        function void report(string what, t_body exp, t_body got);
            errors++;
            if (errors <= 10)
                $display("%s: exp px=%h py=%h vx=%h vy=%h b=%b got px=%h py=%h vx=%h vy=%h b=%b",
                         what, exp.px, exp.py, exp.vx, exp.vy, exp.flag,
                         got.px, got.py, got.vx, got.vy, got.flag);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic [4*W-1:0] i_s_tdata = '0;
    logic [0:0] i_s_tuser = '0;
    logic i_s_tvalid = 0;
    logic o_s_tready;
    logic [4*W-1:0] o_m_tdata;
    logic [0:0] o_m_tuser;
    logic o_m_tvalid;
    logic i_m_tready = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [W-1:0] i_cfg_data = '0;

    t_bounce_scoreboard sb = new();
    int idle_cycles = 0;
    logic quiet = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    box_boundary_bounce_speed_clamp dut (.*);

    // result side: random back-pressure bursts, check every beat
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                sb.check_result({o_m_tdata[127:96], o_m_tdata[95:64],
                                 o_m_tdata[63:32], o_m_tdata[31:0], o_m_tuser[0]});
            if (hold > 0) hold--;
            else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 9);
            i_m_tready <= (hold == 0);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [30:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= {1'b0, val};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_MARGIN:   wall_margin = val;
            REG_BOX_SIZE: world_size = val;
            REG_DAMPING:  bounce_damp = val[16:0];
            default:      max_speed = val;
        endcase
    endtask

    task automatic apply_settings(input logic [30:0] m, input logic [30:0] s,
                                  input logic [16:0] d, input logic [30:0] v);
        write_reg(REG_MARGIN, m);
        write_reg(REG_BOX_SIZE, s);
        write_reg(REG_DAMPING, {14'd0, d});
        write_reg(REG_SPEED_LIMIT, v);
    endtask

    task automatic send_body(input t_body b);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {b.vy, b.vx, b.py, b.px};
        i_s_tuser <= b.flag;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_body(b);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // random coordinate: near either wall, over the full range, or shifted down to a random scale
    function automatic logic [W-1:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return wall_margin + $urandom_range(0, 64) - 32;
            2: return world_size - wall_margin + $urandom_range(0, 64) - 32;
            default: return $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
        endcase
    endfunction

    function automatic logic [W-1:0] rand_vel();
        logic [W-1:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic t_body rand_body();
        t_body b;
        b.px = rand_pos(); b.py = rand_pos();
        b.vx = rand_vel(); b.vy = rand_vel();
        b.flag = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    initial begin
        t_body b;
        wall_margin = 0; world_size = 31'h4000_0000;
        bounce_damp = 17'h10000; max_speed = 31'h7FFF_FFFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes with reset settings
        send_body('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
        send_body('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
        send_body('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1});
        send_body('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        send_body('{32'h0, 32'h0, 32'h0, 32'h0, 1'b0});
        send_body('{32'h1234, 32'h5678, 32'h2000_0000, 32'h1000_0000, 1'b0});
        drain();

        // damping above one with tight speed limit, velocity saturation
        apply_settings(31'h10_0000, 31'h100_0000, 17'h1FFFF, 31'h8_0000);
        send_body('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0});
        send_body('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 32'h0, 1'b0});
        send_body('{32'h0003_0000, 32'hFFFC_0000, 32'h0010_0000, 32'hFFFF_0000, 1'b0});
        send_body('{32'h0003_0000, 32'hFFFC_0000, 32'hFFFF_0000, 32'h0050_0000, 1'b1});
        drain();

        // margin beyond half the box, zero limit, zero damping
        apply_settings(31'h7FFF_FFFF, 31'h0, 17'h0, 31'h0);
        send_body('{32'h1, 32'h1, 32'h7FFF_FFFF, 32'h0, 1'b0});
        send_body('{32'h1, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
        drain();
        apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'h10000, 31'h0);
        send_body('{32'h100, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0});
        send_body('{32'h0, 32'h0, 32'h0, 32'h0, 1'b0});
        drain();

        // random phases over several settings, last one without idling
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) quiet = 1;
            apply_settings(31'($urandom_range(0, 31'h100_0000) >> $urandom_range(0, 8)),
                           31'($urandom_range(0, 31'h7FFF_FFFF) >> $urandom_range(0, 6)),
                           17'($urandom_range(0, 17'h1FFFF)),
                           ph == 0 ? 31'h7FFF_FFFF : 31'($urandom >> $urandom_range(1, 20)));
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                b = rand_body();
                send_body(b);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
